// ===== rtl/tset_pkg.sv =====
// Shared types and constants of the time-sorted event table.
package tset_pkg;

	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 56;
	localparam int unsigned TAG_PORT_W = 32;
	localparam int unsigned IDX_PORT_W = 4;
	localparam int unsigned CNT_PORT_W = 5;
	localparam int unsigned KEY_W      = 11;

	localparam logic [4:0] LAST_HOUR   = 5'd23;
	localparam logic [5:0] LAST_MINUTE = 6'd59;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_FULL     = 3'd1;
	localparam logic [2:0] STAT_EMPTY    = 3'd2;
	localparam logic [2:0] STAT_NO_INDEX = 3'd3;
	localparam logic [2:0] STAT_BAD_TIME = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_INS,
		S_DEL,
		S_RD,
		S_DONE
	} tset_state_t;

	typedef struct packed {
		logic       cap;
		logic       ins_start;
		logic       ins_step;
		logic       del_start;
		logic       del_step;
		logic       rd_start;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_load;
		logic       res_read;
		logic [2:0] res_status;
	} tset_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       bad_time;
		logic       empty;
		logic       bad_index;
		logic       place;
		logic       del_last;
		logic       res_free;
	} tset_sts_t;

endpackage

// ===== rtl/tset_ctrl.sv =====
// Controller state machine that sequences insert, delete and read operations.
module tset_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tset_pkg::tset_sts_t sts,
	output tset_pkg::tset_cmd_t cmd
);

	tset_pkg::tset_state_t state_q, state_d;
	logic [2:0]            status_q, status_d;
	logic                  rdok_q, rdok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tset_pkg::S_IDLE;
			status_q <= tset_pkg::STAT_OK;
			rdok_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			rdok_q   <= rdok_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		rdok_d   = rdok_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tset_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap  = 1'b1;
					status_d = tset_pkg::STAT_OK;
					rdok_d   = 1'b0;
					state_d  = tset_pkg::S_DEC;
				end
			end
			tset_pkg::S_DEC: begin
				state_d = tset_pkg::S_DONE;
				if (sts.op == tset_pkg::OP_INSERT) begin
					if (sts.full) begin
						status_d = tset_pkg::STAT_FULL;
					end else if (sts.bad_time) begin
						status_d = tset_pkg::STAT_BAD_TIME;
					end else begin
						cmd.ins_start = 1'b1;
						state_d       = tset_pkg::S_INS;
					end
				end else if (sts.op == tset_pkg::OP_DELETE || sts.op == tset_pkg::OP_READ) begin
					if (sts.empty) begin
						status_d = tset_pkg::STAT_EMPTY;
					end else if (sts.bad_index) begin
						status_d = tset_pkg::STAT_NO_INDEX;
					end else if (sts.op == tset_pkg::OP_DELETE) begin
						cmd.del_start = 1'b1;
						state_d       = tset_pkg::S_DEL;
					end else begin
						cmd.rd_start = 1'b1;
						state_d      = tset_pkg::S_RD;
					end
				end
			end
			tset_pkg::S_INS: begin
				cmd.ins_step = 1'b1;
				if (sts.place) begin
					cmd.cnt_inc = 1'b1;
					state_d     = tset_pkg::S_DONE;
				end
			end
			tset_pkg::S_DEL: begin
				if (sts.del_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = tset_pkg::S_DONE;
				end else begin
					cmd.del_step = 1'b1;
				end
			end
			tset_pkg::S_RD: begin
				rdok_d  = 1'b1;
				state_d = tset_pkg::S_DONE;
			end
			tset_pkg::S_DONE: begin
				if (sts.res_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = status_q;
					cmd.res_read   = rdok_q;
					state_d        = tset_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tset_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/tset_dp.sv =====
// Datapath of the event table: entry memory, count, shift pointers and result register.
module tset_dp #(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned TAG_BITS    = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [tset_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [tset_pkg::OUT_DATA_W-1:0]     out_data,
	input  tset_pkg::tset_cmd_t                 cmd,
	output tset_pkg::tset_sts_t                 sts
);

	localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IXW = (CW > tset_pkg::IDX_PORT_W) ? CW : tset_pkg::IDX_PORT_W;
	localparam int unsigned EW  = tset_pkg::KEY_W + TAG_BITS;

	logic [EW-1:0]       mem [TABLE_DEPTH];
	logic [EW-1:0]       rd_q;
	logic [1:0]          op_q;
	logic [4:0]          hour_q;
	logic [5:0]          minute_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [IXW-1:0]      idx_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       p_q;
	logic [CW-1:0]       k_q;

	logic                out_valid_q;
	logic [2:0]          res_status_q;
	logic [4:0]          res_count_q;
	logic [4:0]          res_hour_q;
	logic [5:0]          res_minute_q;
	logic [tset_pkg::TAG_PORT_W-1:0] res_tag_q;

	logic [EW-1:0]       new_ent;
	logic [EW-1:0]       wr_data;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic                rd_en;
	logic [CW-1:0]       cm1;
	logic [AW-1:0]       pm1;
	logic [AW-1:0]       pm2;
	logic [CW-1:0]       kp1;
	logic [CW-1:0]       kp2;
	logic [IXW-1:0]      idxp1;
	logic                place;
	logic [63:0]         rd_tag_wide;

	assign new_ent = {tag_q, hour_q, minute_q};
	assign cm1     = count_q - CW'(1);
	assign pm1     = p_q - AW'(1);
	assign pm2     = pm1 - AW'(1);
	assign kp1     = k_q + CW'(1);
	assign kp2     = kp1 + CW'(1);
	assign idxp1   = idx_q + IXW'(1);
	assign place   = (p_q == '0) || (rd_q[tset_pkg::KEY_W-1:0] <= {hour_q, minute_q});
	assign rd_tag_wide = 64'(rd_q[EW-1:tset_pkg::KEY_W]);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = p_q;
		wr_data = new_ent;
		rd_en   = 1'b0;
		rd_addr = cm1[AW-1:0];
		if (cmd.ins_start) begin
			rd_en   = 1'b1;
			rd_addr = cm1[AW-1:0];
		end
		if (cmd.ins_step) begin
			wr_en   = 1'b1;
			wr_addr = p_q;
			wr_data = place ? new_ent : rd_q;
			if (!place) begin
				rd_en   = 1'b1;
				rd_addr = pm2;
			end
		end
		if (cmd.del_start) begin
			rd_en   = 1'b1;
			rd_addr = idxp1[AW-1:0];
		end
		if (cmd.del_step) begin
			wr_en   = 1'b1;
			wr_addr = k_q[AW-1:0];
			wr_data = rd_q;
			rd_en   = 1'b1;
			rd_addr = kp2[AW-1:0];
		end
		if (cmd.rd_start) begin
			rd_en   = 1'b1;
			rd_addr = idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q     <= in_data[1:0];
			hour_q   <= in_data[6:2];
			minute_q <= in_data[12:7];
			tag_q    <= TAG_BITS'(in_data[44:13]);
			idx_q    <= IXW'(in_data[48:45]);
		end
		if (cmd.ins_start) begin
			p_q <= count_q[AW-1:0];
		end else if (cmd.ins_step && !place) begin
			p_q <= pm1;
		end
		if (cmd.del_start) begin
			k_q <= CW'(idx_q);
		end else if (cmd.del_step) begin
			k_q <= kp1;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_count_q  <= tset_pkg::CNT_PORT_W'(count_q);
			res_hour_q   <= cmd.res_read ? rd_q[10:6] : 5'd0;
			res_minute_q <= cmd.res_read ? rd_q[5:0] : 6'd0;
			res_tag_q    <= cmd.res_read ? rd_tag_wide[tset_pkg::TAG_PORT_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= cm1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op        = op_q;
	assign sts.full      = (count_q == CW'(TABLE_DEPTH));
	assign sts.bad_time  = (hour_q > tset_pkg::LAST_HOUR) || (minute_q > tset_pkg::LAST_MINUTE);
	assign sts.empty     = (count_q == '0);
	assign sts.bad_index = (idx_q >= IXW'(count_q));
	assign sts.place     = place;
	assign sts.del_last  = (kp1 >= count_q);
	assign sts.res_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {5'd0, res_tag_q, res_minute_q, res_hour_q, res_count_q, res_status_q};

endmodule

// ===== rtl/time_sorted_event_table.sv =====
// Top level of the time-sorted event table.
// The table holds up to TABLE_DEPTH entries of hour, minute and tag in ascending time
// order. Items arrive on the s_axis channel: an insert places the entry after all
// entries of equal or earlier time, a delete removes the entry at an index and closes
// the gap, and a read returns the entry at an index. Each item gives exactly one
// result item on the m_axis channel, carrying a status code and the entry count.
// Items are handled one at a time. Each item is decoded first; a refused or ignored
// item goes straight on to its result, a read first fetches the entry at its index,
// and an insert or a delete first moves entries one by one in a shift loop over the
// entry memory. The next item can be taken in the cycle after the result is loaded,
// also while that result still waits in the output register. Reset empties the table
// at once; the entry memory itself is not cleared. When the receiver stalls, a finished
// operation waits until the output register frees before its result is loaded.
module time_sorted_event_table #(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned TAG_BITS    = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// Fields from bit 0: operation, event_hour, event_minute, event_tag, slot_index.
	input  logic [tset_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// Fields from bit 0: status, entry_count, read_hour, read_minute, read_tag.
	output logic [tset_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	tset_pkg::tset_cmd_t cmd;
	tset_pkg::tset_sts_t sts;

	tset_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tset_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef ASSERT_OFF
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("a second item was offered for acceptance straight after the first");

	a_read_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] != tset_pkg::STAT_OK) |->
		m_axis_tdata[50:8] == '0)
		else $error("a refused item carries non-zero read fields");

	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.res_load))
		else $error("a result appeared without being loaded by the controller");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !m_axis_tvalid || m_axis_tready)
		else $error("a result was loaded over one still waiting");
`endif

endmodule

// ===== tb/time_sorted_event_table_tb.sv =====
// Self-checking testbench of the time-sorted event table with stream driver, predictor and checker.
`timescale 1ns / 1ps

module time_sorted_event_table_tb;

	localparam int unsigned DEPTH        = 16;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned HOLD_AFTER   = 300;
	localparam int unsigned HOLD_CYCLES  = 600;
	localparam int unsigned PRINT_MAX    = 50;
	localparam logic [1:0]  OP_UNUSED    = 2'd3;

	typedef struct packed {
		logic [3:0]  slot;
		logic [31:0] tag;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [1:0]  op;
	} table_cmd_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  count;
		logic [2:0]  status;
	} table_res_t;

	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [31:0] tag;
	} table_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [tset_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [tset_pkg::OUT_DATA_W-1:0] m_tdata;

	table_cmd_t   pending_items[$];
	table_res_t   expected_results[$];
	table_entry_t sorted_entries[DEPTH];
	int unsigned  held_entries = 0;
	int unsigned  held_peak = 0;
	int unsigned  plan_count = 0;

	table_cmd_t   on_bus;
	int unsigned  gap_left, gap_next;
	logic         offer_next;
	int unsigned  stall_left, stall_next;
	int unsigned  hold_left;
	logic         hold_done;
	int unsigned  items_taken = 0;
	int unsigned  results_seen = 0;
	int unsigned  err_count = 0;
	int unsigned  status_seen[8];
	int unsigned  cycle_count = 0;

	time_sorted_event_table #(
		.TABLE_DEPTH(DEPTH),
		.TAG_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Works out the answer to one operation and updates the sorted table.
	function automatic table_res_t predict_table_op(table_cmd_t c);
		table_res_t r;
		int p;
		r = '0;
		r.status = tset_pkg::STAT_OK;
		case (c.op)
		tset_pkg::OP_INSERT: begin
			if (held_entries >= DEPTH) begin
				r.status = tset_pkg::STAT_FULL;
			end else if (c.hour > tset_pkg::LAST_HOUR || c.minute > tset_pkg::LAST_MINUTE) begin
				r.status = tset_pkg::STAT_BAD_TIME;
			end else begin
				p = held_entries;
				while (p > 0 && {sorted_entries[p-1].hour, sorted_entries[p-1].minute} >
						{c.hour, c.minute}) begin
					sorted_entries[p] = sorted_entries[p-1];
					p--;
				end
				sorted_entries[p] = '{hour: c.hour, minute: c.minute, tag: c.tag};
				held_entries++;
				if (held_entries > held_peak)
					held_peak = held_entries;
			end
		end
		tset_pkg::OP_DELETE, tset_pkg::OP_READ: begin
			if (held_entries == 0) begin
				r.status = tset_pkg::STAT_EMPTY;
			end else if (c.slot >= held_entries) begin
				r.status = tset_pkg::STAT_NO_INDEX;
			end else if (c.op == tset_pkg::OP_DELETE) begin
				for (p = int'(c.slot); p + 1 < held_entries; p++)
					sorted_entries[p] = sorted_entries[p+1];
				held_entries--;
			end else begin
				r.hour   = sorted_entries[c.slot].hour;
				r.minute = sorted_entries[c.slot].minute;
				r.tag    = sorted_entries[c.slot].tag;
			end
		end
		default: ;
		endcase
		r.count = held_entries[4:0];
		return r;
	endfunction

	// Every third stretch of 150 items runs with no idling at all.
	function automatic int unsigned idle_draw(int unsigned n);
		if ((n / 150) % 3 == 1)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	task automatic queue_item(input logic [1:0] op, input logic [4:0] hour,
			input logic [5:0] minute, input logic [31:0] tag, input logic [3:0] slot);
		pending_items.push_back('{slot: slot, tag: tag, minute: minute, hour: hour, op: op});
		if (op == tset_pkg::OP_INSERT && plan_count < DEPTH && hour <= tset_pkg::LAST_HOUR &&
				minute <= tset_pkg::LAST_MINUTE)
			plan_count++;
		else if (op == tset_pkg::OP_DELETE && slot < plan_count)
			plan_count--;
	endtask

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (err_count < PRINT_MAX)
			$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		err_count++;
	endtask

	task automatic check_result(input table_res_t got);
		table_res_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected result", 64'(got), 64'd0);
		end else begin
			want = expected_results.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.count !== want.count)
				report_mismatch("entry count", 64'(got.count), 64'(want.count));
			if (got.hour !== want.hour)
				report_mismatch("read hour", 64'(got.hour), 64'(want.hour));
			if (got.minute !== want.minute)
				report_mismatch("read minute", 64'(got.minute), 64'(want.minute));
			if (got.tag !== want.tag)
				report_mismatch("read tag", 64'(got.tag), 64'(want.tag));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_left <= 0;
		end else begin
			offer_next = s_tvalid;
			gap_next = gap_left;
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_table_op(on_bus));
				items_taken <= items_taken + 1;
				offer_next = 1'b0;
				gap_next = idle_draw(items_taken);
			end
			if (!offer_next) begin
				if (gap_next > 0) begin
					gap_next--;
				end else if (pending_items.size() != 0) begin
					on_bus = pending_items.pop_front();
					offer_next = 1'b1;
					s_tdata <= {{(tset_pkg::IN_DATA_W - $bits(table_cmd_t)){1'b0}}, on_bus};
				end
			end
			gap_left <= gap_next;
			s_tvalid <= offer_next;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			stall_next = stall_left;
			if (m_tvalid && m_tready) begin
				check_result(m_tdata[$bits(table_res_t)-1:0]);
				status_seen[m_tdata[2:0]] <= status_seen[m_tdata[2:0]] + 1;
				results_seen <= results_seen + 1;
				stall_next = idle_draw(results_seen);
			end else if (stall_next > 0) begin
				stall_next--;
			end
			stall_left <= stall_next;
			m_tready <= (stall_next == 0) && (hold_left == 0);
		end
	end

	// The receiver holds off once for a long stretch so that the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles.", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned r, k, mode;
		logic [1:0] op;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [3:0] slot;

		queue_item(tset_pkg::OP_READ, 5'd0, 6'd0, 32'h0, 4'd0);
		queue_item(tset_pkg::OP_DELETE, 5'd0, 6'd0, 32'h0, 4'd15);
		queue_item(OP_UNUSED, 5'd31, 6'd63, 32'hFFFF_FFFF, 4'd15);
		queue_item(tset_pkg::OP_INSERT, 5'd23, 6'd59, 32'hFFFF_FFFF, 4'd0);
		queue_item(tset_pkg::OP_INSERT, 5'd0, 6'd0, 32'h0, 4'd15);
		queue_item(tset_pkg::OP_INSERT, 5'd12, 6'd30, 32'hA5A5_0001, 4'd0);
		queue_item(tset_pkg::OP_INSERT, 5'd12, 6'd30, 32'h5A5A_0002, 4'd0);
		queue_item(tset_pkg::OP_INSERT, 5'd24, 6'd0, 32'h1111_1111, 4'd0);
		queue_item(tset_pkg::OP_INSERT, 5'd0, 6'd60, 32'h2222_2222, 4'd0);
		queue_item(tset_pkg::OP_INSERT, 5'd31, 6'd63, 32'h3333_3333, 4'd0);
		for (k = 0; k < 4; k++)
			queue_item(tset_pkg::OP_READ, 5'd31, 6'd63, 32'hFFFF_FFFF, k[3:0]);
		queue_item(tset_pkg::OP_READ, 5'd0, 6'd0, 32'h0, 4'd15);
		queue_item(tset_pkg::OP_DELETE, 5'd0, 6'd0, 32'h0, 4'd4);
		queue_item(tset_pkg::OP_DELETE, 5'd0, 6'd0, 32'h0, 4'd1);
		queue_item(tset_pkg::OP_READ, 5'd0, 6'd0, 32'h0, 4'd1);
		queue_item(OP_UNUSED, 5'd0, 6'd0, 32'h0, 4'd0);

		// Random part in stretches that fill, drain or mix, with many equal times.
		mode = 0;
		for (int n = 0; n < 1000; n++) begin
			if (n % 60 == 0)
				mode = $urandom_range(0, 2);
			r = $urandom_range(0, 99);
			if (r >= 97)
				op = OP_UNUSED;
			else if (r < (mode == 0 ? 70 : mode == 1 ? 20 : 40))
				op = tset_pkg::OP_INSERT;
			else if (r < (mode == 0 ? 85 : mode == 1 ? 70 : 60))
				op = tset_pkg::OP_DELETE;
			else
				op = tset_pkg::OP_READ;
			k = $urandom_range(0, 9);
			if (k == 0) begin
				hour = 5'($urandom_range(24, 31));
				minute = 6'($urandom_range(0, 63));
			end else if (k == 1) begin
				hour = 5'($urandom_range(0, 23));
				minute = 6'($urandom_range(60, 63));
			end else if (k < 5) begin
				hour = 5'($urandom_range(8, 10));
				minute = 6'($urandom_range(0, 2) * 15);
			end else begin
				hour = 5'($urandom_range(0, 23));
				minute = 6'($urandom_range(0, 59));
			end
			if (plan_count > 0 && $urandom_range(0, 9) < 8)
				slot = 4'($urandom_range(0, plan_count - 1));
			else
				slot = 4'($urandom_range(0, 15));
			queue_item(op, hour, minute, $urandom, slot);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d operations and checked %0d answers; the table held up to %0d of %0d.",
			items_taken, results_seen, held_peak, DEPTH);
		$display("Answers by status: ok %0d, full %0d, empty %0d, no index %0d, bad time %0d.",
			status_seen[tset_pkg::STAT_OK], status_seen[tset_pkg::STAT_FULL],
			status_seen[tset_pkg::STAT_EMPTY], status_seen[tset_pkg::STAT_NO_INDEX],
			status_seen[tset_pkg::STAT_BAD_TIME]);
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches found.", err_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
